// ===== rtl/icns_plane_run_length_encoder_macros.svh =====
// Assertion helpers for the plane run-length encoder.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ICNS_PLANE_RUN_LENGTH_ENCODER_MACROS_SVH
`define ICNS_PLANE_RUN_LENGTH_ENCODER_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ICNS_RLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ICNS_RLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// What must hold in the cycle after each cycle in which reset is asserted.
`define ICNS_RLE_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/icns_rle_pkg.sv =====
package icns_rle_pkg;

  localparam int BYTE_W  = 8;
  localparam int DATA_W  = 64;
  localparam int COUNT_W = 4;
  localparam int MIN_RUN = 3;

  localparam logic [BYTE_W-1:0] RUN_BASE = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN_CTL,
    ST_RUN_VAL,
    ST_LIT_CTL,
    ST_LIT_DATA
  } icns_rle_state_t;

  // One encoded byte handed from the sequencer to the packer.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              stream_end;
  } icns_rle_push_t;

endpackage

// ===== rtl/icns_rle_store.sv =====
module icns_rle_store #(
  parameter int AW = 8
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [icns_rle_pkg::BYTE_W-1:0] wr_data,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output logic [icns_rle_pkg::BYTE_W-1:0] rd_data
);

  localparam int DEPTH = 1 << AW;

  logic [icns_rle_pkg::BYTE_W-1:0] mem_r [DEPTH];
  logic [icns_rle_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/icns_rle_pack.sv =====
module icns_rle_pack #(
  parameter int OUT_BYTES = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  icns_rle_pkg::icns_rle_push_t     push,
  output logic                             push_ready,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [icns_rle_pkg::DATA_W-1:0]  out_packed_bytes,
  output logic [icns_rle_pkg::COUNT_W-1:0] out_byte_count,
  output logic                             out_stream_end
);

  localparam int BW = $clog2(OUT_BYTES + 1);

  logic [icns_rle_pkg::BYTE_W-1:0]  acc_r [OUT_BYTES];
  logic [BW-1:0]                    acc_cnt_r;
  logic [BW-1:0]                    acc_cnt_nxt;
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  logic [icns_rle_pkg::DATA_W-1:0]  out_data_r;
  logic [icns_rle_pkg::COUNT_W-1:0] out_cnt_r;
  logic                             out_end_r;
  logic                             complete;
  logic                             take;
  logic [icns_rle_pkg::DATA_W-1:0]  word_c;

  // A word closes on the step's last byte or when every lane is filled.
  assign complete   = push.last || (acc_cnt_r == BW'(OUT_BYTES - 1));
  assign push_ready = !complete || !out_valid_r || !out_stall;
  assign take       = push.valid && push_ready;

  // Lanes above the fill count stay zero.
  always_comb begin
    word_c = '0;
    for (int i = 0; i < OUT_BYTES; i++) begin
      if (BW'(i) == acc_cnt_r) begin
        word_c[8*i +: 8] = push.data;
      end else if (BW'(i) < acc_cnt_r) begin
        word_c[8*i +: 8] = acc_r[i];
      end
    end
  end

  always_comb begin
    acc_cnt_nxt   = acc_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (take) begin
      if (complete) begin
        acc_cnt_nxt   = '0;
        out_valid_nxt = 1'b1;
      end else begin
        acc_cnt_nxt = acc_cnt_r + BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_cnt_r   <= acc_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !complete) begin
      for (int i = 0; i < OUT_BYTES; i++) begin
        if (BW'(i) == acc_cnt_r) begin
          acc_r[i] <= push.data;
        end
      end
    end
    if (take && complete) begin
      out_data_r <= word_c;
      out_cnt_r  <= icns_rle_pkg::COUNT_W'(acc_cnt_r) + icns_rle_pkg::COUNT_W'(1);
      out_end_r  <= push.stream_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_packed_bytes = out_data_r;
  assign out_byte_count   = out_cnt_r;
  assign out_stream_end   = out_end_r;

endmodule

// ===== rtl/icns_rle_ctrl.sv =====
module icns_rle_ctrl #(
  parameter int MAX_LITERAL = 128,
  parameter int MAX_REPEAT  = 130,
  parameter int AW          = 8,
  parameter int CW          = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [icns_rle_pkg::BYTE_W-1:0] in_value,
  input  logic                            in_plane_end,
  output icns_rle_pkg::icns_rle_push_t    push,
  input  logic                            push_ready,
  output logic                            wr_en,
  output logic [AW-1:0]                   wr_addr,
  output logic [icns_rle_pkg::BYTE_W-1:0] wr_data,
  output logic                            rd_en,
  output logic [AW-1:0]                   rd_addr,
  input  logic [icns_rle_pkg::BYTE_W-1:0] rd_data
);

  localparam logic [CW-1:0] LIT_MAX  = CW'(MAX_LITERAL);
  localparam logic [CW-1:0] LIT_FULL = CW'(MAX_LITERAL + 2);
  localparam logic [CW-1:0] REP_MAX  = CW'(MAX_REPEAT);
  localparam logic [CW-1:0] RUN_MIN  = CW'(icns_rle_pkg::MIN_RUN);

  icns_rle_pkg::icns_rle_state_t state_r, state_nxt;

  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [CW-1:0]                   run_len_r, run_len_nxt;
  logic [icns_rle_pkg::BYTE_W-1:0] run_byte_r, run_byte_nxt;
  logic [icns_rle_pkg::BYTE_W-1:0] last1_r, last1_nxt;
  logic [icns_rle_pkg::BYTE_W-1:0] last2_r, last2_nxt;
  logic [AW-1:0]                   head_r, head_nxt;
  logic [AW-1:0]                   tail_r, tail_nxt;
  logic [AW-1:0]                   rd_ptr_r, rd_ptr_nxt;
  logic                            end_r, end_nxt;
  logic                            run_pre_r, run_pre_nxt;
  logic                            run_post_r, run_post_nxt;
  logic [icns_rle_pkg::BYTE_W-1:0] run_ctl_r, run_ctl_nxt;
  logic [icns_rle_pkg::BYTE_W-1:0] run_val_r, run_val_nxt;
  logic [CW-1:0]                   lit_len_r, lit_len_nxt;
  logic [CW-1:0]                   lit2_r, lit2_nxt;

  logic          accept;
  logic [CW-1:0] n1;
  logic          in_run;
  logic          same_rb;
  logic          ext;
  logic          triple;
  logic [CW-1:0] end_lit;
  logic          lit_more;

  assign accept   = in_valid && (state_r == icns_rle_pkg::ST_IDLE);
  assign in_stall = (state_r != icns_rle_pkg::ST_IDLE);

  assign n1      = cnt_r + CW'(1);
  assign in_run  = (run_len_r >= RUN_MIN);
  assign same_rb = (in_value == run_byte_r);
  // The new byte extends a head run that spans every pending byte.
  assign ext     = (cnt_r != '0) && (run_len_r == cnt_r) && same_rb;
  // Three equal bytes now begin two places before the new byte.
  assign triple  = (cnt_r >= CW'(2)) && (last1_r == in_value) && (last2_r == in_value);
  assign end_lit = (n1 > LIT_MAX) ? LIT_MAX : n1;
  assign lit_more = run_pre_r && (lit_len_r != '0);

  assign wr_addr = tail_r;
  assign wr_data = in_value;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    run_len_nxt  = run_len_r;
    run_byte_nxt = run_byte_r;
    last1_nxt    = last1_r;
    last2_nxt    = last2_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    rd_ptr_nxt   = rd_ptr_r;
    end_nxt      = end_r;
    run_pre_nxt  = run_pre_r;
    run_post_nxt = run_post_r;
    run_ctl_nxt  = run_ctl_r;
    run_val_nxt  = run_val_r;
    lit_len_nxt  = lit_len_r;
    lit2_nxt     = lit2_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = rd_ptr_r;
    push         = '0;

    unique case (state_r)
      icns_rle_pkg::ST_IDLE: begin
        if (accept) begin
          last2_nxt    = last1_r;
          last1_nxt    = in_value;
          end_nxt      = in_plane_end;
          run_pre_nxt  = 1'b0;
          run_post_nxt = 1'b0;
          lit_len_nxt  = '0;
          lit2_nxt     = '0;
          rd_ptr_nxt   = head_r;

          if (in_run) begin
            if (same_rb) begin
              if ((n1 == REP_MAX) || in_plane_end) begin
                run_pre_nxt = 1'b1;
                run_ctl_nxt = icns_rle_pkg::RUN_BASE + 8'(n1 - RUN_MIN);
                run_val_nxt = run_byte_r;
                cnt_nxt     = '0;
                run_len_nxt = '0;
              end else begin
                cnt_nxt     = n1;
                run_len_nxt = n1;
              end
            end else begin
              // Close the run, then start a fresh literal at the tail.
              run_pre_nxt  = 1'b1;
              run_ctl_nxt  = icns_rle_pkg::RUN_BASE + 8'(run_len_r - RUN_MIN);
              run_val_nxt  = run_byte_r;
              wr_en        = 1'b1;
              rd_ptr_nxt   = tail_r;
              head_nxt     = tail_r;
              tail_nxt     = tail_r + AW'(1);
              cnt_nxt      = CW'(1);
              run_len_nxt  = CW'(1);
              run_byte_nxt = in_value;
              if (in_plane_end) begin
                lit_len_nxt = CW'(1);
              end
            end
          end else if (ext && (n1 >= RUN_MIN)) begin
            // Pending bytes turn into a run; drop them from the store.
            head_nxt = tail_r;
            if ((n1 == REP_MAX) || in_plane_end) begin
              run_pre_nxt = 1'b1;
              run_ctl_nxt = icns_rle_pkg::RUN_BASE + 8'(n1 - RUN_MIN);
              run_val_nxt = run_byte_r;
              cnt_nxt     = '0;
              run_len_nxt = '0;
            end else begin
              cnt_nxt     = n1;
              run_len_nxt = n1;
            end
          end else if (triple) begin
            // Flush the literal ahead of the triple; the triple becomes a run.
            lit_len_nxt = cnt_r - CW'(2);
            head_nxt    = tail_r;
            if ((REP_MAX == RUN_MIN) || in_plane_end) begin
              run_post_nxt = 1'b1;
              run_ctl_nxt  = icns_rle_pkg::RUN_BASE;
              run_val_nxt  = in_value;
              cnt_nxt      = '0;
              run_len_nxt  = '0;
            end else begin
              cnt_nxt      = RUN_MIN;
              run_len_nxt  = RUN_MIN;
              run_byte_nxt = in_value;
            end
          end else begin
            wr_en    = 1'b1;
            tail_nxt = tail_r + AW'(1);
            cnt_nxt  = n1;
            if (cnt_r == '0) begin
              run_len_nxt  = CW'(1);
              run_byte_nxt = in_value;
            end else if (ext) begin
              run_len_nxt = n1;
            end
            if (in_plane_end) begin
              lit_len_nxt = end_lit;
              lit2_nxt    = n1 - end_lit;
            end else if (n1 == LIT_FULL) begin
              // Literal is full; the last two bytes stay pending.
              lit_len_nxt  = LIT_MAX;
              head_nxt     = head_r + AW'(MAX_LITERAL);
              cnt_nxt      = CW'(2);
              run_len_nxt  = (last1_r == in_value) ? CW'(2) : CW'(1);
              run_byte_nxt = last1_r;
            end
          end

          if (in_plane_end) begin
            cnt_nxt      = '0;
            run_len_nxt  = '0;
            run_byte_nxt = '0;
            head_nxt     = tail_nxt;
          end

          if (run_pre_nxt) begin
            state_nxt = icns_rle_pkg::ST_RUN_CTL;
          end else if (lit_len_nxt != '0) begin
            state_nxt = icns_rle_pkg::ST_LIT_CTL;
          end
        end
      end

      icns_rle_pkg::ST_RUN_CTL: begin
        push.valid = 1'b1;
        push.data  = run_ctl_r;
        if (push_ready) begin
          state_nxt = icns_rle_pkg::ST_RUN_VAL;
        end
      end

      icns_rle_pkg::ST_RUN_VAL: begin
        push.valid      = 1'b1;
        push.data       = run_val_r;
        push.last       = !lit_more;
        push.stream_end = end_r && !lit_more;
        if (push_ready) begin
          if (lit_more) begin
            run_pre_nxt = 1'b0;
            state_nxt   = icns_rle_pkg::ST_LIT_CTL;
          end else begin
            state_nxt = icns_rle_pkg::ST_IDLE;
          end
        end
      end

      icns_rle_pkg::ST_LIT_CTL: begin
        // Prefetch the first literal byte while the control byte goes out.
        push.valid = 1'b1;
        push.data  = 8'(lit_len_r - CW'(1));
        rd_en      = 1'b1;
        if (push_ready) begin
          state_nxt = icns_rle_pkg::ST_LIT_DATA;
        end
      end

      icns_rle_pkg::ST_LIT_DATA: begin
        push.valid      = 1'b1;
        push.data       = rd_data;
        push.last       = (lit_len_r == CW'(1)) && (lit2_r == '0) && !run_post_r;
        push.stream_end = end_r && push.last;
        if (push_ready) begin
          rd_en       = 1'b1;
          rd_addr     = rd_ptr_r + AW'(1);
          rd_ptr_nxt  = rd_ptr_r + AW'(1);
          lit_len_nxt = lit_len_r - CW'(1);
          if (lit_len_r == CW'(1)) begin
            if (lit2_r != '0) begin
              lit_len_nxt = lit2_r;
              lit2_nxt    = '0;
              state_nxt   = icns_rle_pkg::ST_LIT_CTL;
            end else if (run_post_r) begin
              state_nxt = icns_rle_pkg::ST_RUN_CTL;
            end else begin
              state_nxt = icns_rle_pkg::ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = icns_rle_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= icns_rle_pkg::ST_IDLE;
      cnt_r      <= '0;
      run_len_r  <= '0;
      run_byte_r <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      end_r      <= 1'b0;
      run_pre_r  <= 1'b0;
      run_post_r <= 1'b0;
      lit_len_r  <= '0;
      lit2_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      run_len_r  <= run_len_nxt;
      run_byte_r <= run_byte_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      end_r      <= end_nxt;
      run_pre_r  <= run_pre_nxt;
      run_post_r <= run_post_nxt;
      lit_len_r  <= lit_len_nxt;
      lit2_r     <= lit2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last1_r   <= last1_nxt;
    last2_r   <= last2_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    run_ctl_r <= run_ctl_nxt;
    run_val_r <= run_val_nxt;
  end

endmodule

// ===== rtl/icns_plane_run_length_encoder.sv =====
// Channel  | Direction | Handshake          | Word
// ---------+-----------+--------------------+----------------------------------------
// in_      | input     | in_valid/in_stall  | value[7:0], plane_end
// out_     | output    | out_valid/out_stall| packed_bytes[63:0], byte_count[3:0],
//          |           |                    | stream_end
//
// The sequencer moves one encoded byte per cycle into the packer while push_ready is
// high, and literal bytes come out of the pending memory one read a cycle; no new input
// word is taken until every encoded byte that the last one released has been sent.
// Reset is synchronous, active low; the pending memory keeps its contents and needs
// no clearing pass, as head/tail pointers and the fill count bound every read.
// in_stall is high while released bytes are sequenced; out_stall holds the result
// register and stalls the sequencer only when a word closes on a full register.
module icns_plane_run_length_encoder #(
  parameter int MAX_LITERAL = 128,
  parameter int MAX_REPEAT  = 130,
  parameter int OUT_BYTES   = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [icns_rle_pkg::BYTE_W-1:0]  in_value,
  input  logic                             in_plane_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [icns_rle_pkg::DATA_W-1:0]  out_packed_bytes,
  output logic [icns_rle_pkg::COUNT_W-1:0] out_byte_count,
  output logic                             out_stream_end
);

  // Pending bytes never exceed a full literal plus the two lookahead bytes,
  // so the circular store only has to cover that span.
  localparam int CNT_MAX = (MAX_REPEAT > MAX_LITERAL + 2) ? MAX_REPEAT : MAX_LITERAL + 2;
  localparam int CW      = $clog2(CNT_MAX + 1);
  localparam int AW      = $clog2(MAX_LITERAL + 2);

  icns_rle_pkg::icns_rle_push_t    push;
  logic                            push_ready;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  logic [icns_rle_pkg::BYTE_W-1:0] wr_data;
  logic                            rd_en;
  logic [AW-1:0]                   rd_addr;
  logic [icns_rle_pkg::BYTE_W-1:0] rd_data;

  // Decide the greedy blocks per input word and sequence their bytes.
  icns_rle_ctrl #(
    .MAX_LITERAL (MAX_LITERAL),
    .MAX_REPEAT  (MAX_REPEAT),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_plane_end (in_plane_end),
    .push         (push),
    .push_ready   (push_ready),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  // Pending literal bytes, written at the tail, read back from the head.
  icns_rle_store #(
    .AW (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Gather encoded bytes into result words, first byte in the low lane.
  icns_rle_pack #(
    .OUT_BYTES (OUT_BYTES)
  ) u_pack (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .push_ready       (push_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_packed_bytes (out_packed_bytes),
    .out_byte_count   (out_byte_count),
    .out_stream_end   (out_stream_end)
  );

endmodule

// ===== rtl/icns_rle_checker.sv =====
`include "icns_plane_run_length_encoder_macros.svh"

module icns_rle_checker #(
  parameter int OUT_BYTES = 8
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [icns_rle_pkg::DATA_W-1:0]  out_packed_bytes,
  input logic [icns_rle_pkg::COUNT_W-1:0] out_byte_count,
  input logic                             out_stream_end
);

  // Come out of reset empty and ready for a word.
  `ICNS_RLE_ASSERT_RST(a_reset_idle, !out_valid && !in_stall, "not idle after reset")

  `ICNS_RLE_ASSERT_IMP(a_count_range, out_valid, (out_byte_count != 4'd0) && (out_byte_count <= OUT_BYTES), "byte count out of range")

  // Lanes past the byte count carry zero.
  `ICNS_RLE_ASSERT_IMP(a_upper_zero, out_valid, (out_packed_bytes >> {out_byte_count, 3'b000}) == 64'd0, "bytes above count not zero")

  `ICNS_RLE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_packed_bytes) && $stable(out_byte_count) && $stable(out_stream_end), "stalled word changed")

endmodule

bind icns_plane_run_length_encoder icns_rle_checker #(
  .OUT_BYTES (OUT_BYTES)
) u_icns_rle_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_packed_bytes (out_packed_bytes),
  .out_byte_count   (out_byte_count),
  .out_stream_end   (out_stream_end)
);

// ===== bench/icns_rle_stream_checker.sv =====
module icns_rle_stream_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [icns_rle_pkg::BYTE_W-1:0]  in_value,
  input  logic                             in_plane_end,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [icns_rle_pkg::DATA_W-1:0]  out_packed_bytes,
  input  logic [icns_rle_pkg::COUNT_W-1:0] out_byte_count,
  input  logic                             out_stream_end,
  output int                               fail_count,
  output int                               words_due
);

  localparam int MAX_LITERAL = 128;
  localparam int MAX_REPEAT  = 130;
  localparam int OUT_BYTES   = 8;
  localparam int HOLD_DEPTH  = 132;

  typedef struct packed {
    logic [icns_rle_pkg::DATA_W-1:0]  bytes;
    logic [icns_rle_pkg::COUNT_W-1:0] count;
    logic                             last;
  } coded_word_t;

  coded_word_t coded_words[$];
  logic [7:0]  held[0:HOLD_DEPTH-1];
  int          held_cnt = 0;
  logic [7:0]  coded_bytes[$];
  int          errs = 0;

  function automatic int head_run();
    int r;
    r = 0;
    if (held_cnt > 0) begin
      r = 1;
      while (r < held_cnt && held[r] == held[0]) r++;
    end
    return r;
  endfunction

  task automatic drop_held(input int k);
    for (int i = 0; i + k < held_cnt; i++) held[i] = held[i + k];
    held_cnt -= k;
  endtask

  // Emit every block whose greedy choice is already certain.
  task automatic release_blocks(input logic last);
    int         n;
    int         r;
    int         lit;
    bit         stop;
    bit         undecided;
    bit         cut;
    logic [7:0] ctl;
    stop = 1'b0;
    while (held_cnt > 0 && !stop) begin
      n = held_cnt;
      r = head_run();
      if (r > MAX_REPEAT) r = MAX_REPEAT;
      if (r >= icns_rle_pkg::MIN_RUN) begin
        if (r == MAX_REPEAT || r < n || last) begin
          ctl = r - icns_rle_pkg::MIN_RUN;
          coded_bytes.push_back(icns_rle_pkg::RUN_BASE + ctl);
          coded_bytes.push_back(held[0]);
          drop_held(r);
        end else begin
          stop = 1'b1;
        end
      end else begin
        lit = 0;
        undecided = 1'b0;
        cut = 1'b0;
        while (lit < MAX_LITERAL && !undecided && !cut) begin
          if (lit >= n) begin
            if (last) cut = 1'b1;
            else undecided = 1'b1;
          end else if (lit + 2 < n) begin
            if (held[lit] == held[lit + 1] && held[lit] == held[lit + 2]) cut = 1'b1;
            else lit++;
          end else if (last) begin
            lit++;
          end else begin
            undecided = 1'b1;
          end
        end
        if (undecided || lit == 0) begin
          stop = 1'b1;
        end else begin
          ctl = lit - 1;
          coded_bytes.push_back(ctl);
          for (int i = 0; i < lit; i++) coded_bytes.push_back(held[i]);
          drop_held(lit);
        end
      end
    end
  endtask

  // Take one plane byte and queue the result words it releases.
  task automatic encode_byte(input logic [7:0] v, input logic last);
    logic [icns_rle_pkg::DATA_W-1:0] acc;
    int                              k;
    coded_word_t                     w;
    if (held_cnt < HOLD_DEPTH) begin
      held[held_cnt] = v;
      held_cnt++;
    end
    coded_bytes.delete();
    release_blocks(last);
    if (last) held_cnt = 0;
    while (coded_bytes.size() > 0) begin
      acc = '0;
      k = 0;
      while (k < OUT_BYTES && coded_bytes.size() > 0) begin
        acc[k*8 +: 8] = coded_bytes.pop_front();
        k++;
      end
      w.bytes = acc;
      w.count = k[icns_rle_pkg::COUNT_W-1:0];
      w.last  = last && coded_bytes.size() == 0;
      coded_words.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    coded_word_t want;
    if (!rst_n) begin
      held_cnt = 0;
      coded_words.delete();
    end else begin
      if (in_valid && !in_stall) encode_byte(in_value, in_plane_end);
      if (out_valid && !out_stall) begin
        if (coded_words.size() == 0) begin
          $display("%0t: unexpected word bytes=%h count=%0d end=%b, expected none", $time,
                   out_packed_bytes, out_byte_count, out_stream_end);
          errs++;
        end else begin
          want = coded_words.pop_front();
          if (out_packed_bytes !== want.bytes) begin
            $display("%0t: packed_bytes expected %h, got %h", $time, want.bytes,
                     out_packed_bytes);
            errs++;
          end
          if (out_byte_count !== want.count) begin
            $display("%0t: byte_count expected %0d, got %0d", $time, want.count,
                     out_byte_count);
            errs++;
          end
          if (out_stream_end !== want.last) begin
            $display("%0t: stream_end expected %b, got %b", $time, want.last,
                     out_stream_end);
            errs++;
          end
        end
      end
    end
    fail_count <= errs;
    words_due  <= coded_words.size();
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;

  // Run limits: generous watchdog, settle time once the last word is in.
  localparam int LIMIT      = 600000;
  localparam int RAND_ITEMS = 200;
  localparam int SETTLE     = 64;

  // Receiver stall patterns.
  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;
  localparam int STALL_LONG  = 3;

  // Kinds of segment a random plane is built from.
  localparam int SEG_RUN     = 0;
  localparam int SEG_LITERAL = 1;
  localparam int SEG_NOISE   = 2;

  logic                             clk;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [icns_rle_pkg::BYTE_W-1:0]  in_value = '0;
  logic                             in_plane_end = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [icns_rle_pkg::DATA_W-1:0]  out_packed_bytes;
  logic [icns_rle_pkg::COUNT_W-1:0] out_byte_count;
  logic                             out_stream_end;

  int         fail_count;
  int         words_due;
  int         cyc = 0;
  int         burst_left = 0;
  int         rand_sent = 0;
  logic [7:0] plane_q[$];

  int   stall_mode = STALL_NONE;
  int   mode_left = 0;
  int   hold_left = 0;
  logic hold_val = 1'b0;

  icns_plane_run_length_encoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_plane_end     (in_plane_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_packed_bytes (out_packed_bytes),
    .out_byte_count   (out_byte_count),
    .out_stream_end   (out_stream_end)
  );

  // Watch both channels, predict the encoded stream and compare word by word.
  icns_rle_stream_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_plane_end     (in_plane_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_packed_bytes (out_packed_bytes),
    .out_byte_count   (out_byte_count),
    .out_stream_end   (out_stream_end),
    .fail_count       (fail_count),
    .words_due        (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // Abort a hung run.
  initial begin
    wait (cyc >= LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: pick a stall pattern, keep it for a random stretch, then switch.
  // The long pattern alternates stall between held-high and held-low spans of random length.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_LONG);
      mode_left = $urandom_range(16, 200);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left == 0) begin
          hold_val = !hold_val;
          hold_left = $urandom_range(1, 20);
        end
        hold_left--;
        out_stall <= hold_val;
      end
    endcase
  end

  // Present one word and hold it until accepted. When the burst runs out,
  // drop valid for a random gap and draw the next burst length; most bursts
  // are short, some long enough to give stretches with no idling.
  task automatic send_word(input logic [7:0] v, input logic last);
    in_valid     <= 1'b1;
    in_value     <= v;
    in_plane_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Send the queued plane, flagging its final byte, and clear the queue.
  task automatic send_plane();
    for (int i = 0; i < plane_q.size(); i++) send_word(plane_q[i], i == plane_q.size() - 1);
    plane_q.delete();
  endtask

  task automatic add_run(input logic [7:0] v, input int len);
    repeat (len) plane_q.push_back(v);
  endtask

  // Append random bytes in 0..span; with no_triple set, bump any byte that
  // would complete three equal bytes so the block stays a literal.
  task automatic add_bytes(input int len, input int span, input bit no_triple);
    logic [7:0] b;
    repeat (len) begin
      b = $urandom_range(0, span);
      if (no_triple && plane_q.size() >= 2 && b == plane_q[$] && b == plane_q[$-1]) b = b + 1;
      plane_q.push_back(b);
    end
  endtask

  // Hold off the sender until every predicted word has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  // Build a plane from a few segments: short runs (sometimes medium ones),
  // literal stretches, and noise over a narrow or full byte range. Narrow
  // noise makes chance runs that cut literal blocks early.
  task automatic build_random_plane();
    int nseg;
    int kind;
    nseg = $urandom_range(1, 6);
    repeat (nseg) begin
      kind = $urandom_range(SEG_RUN, SEG_NOISE);
      case (kind)
        SEG_RUN:
          add_run($urandom_range(0, 255), ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                                       : $urandom_range(1, 6));
        SEG_LITERAL: add_bytes($urandom_range(1, 12), 255, 1'b1);
        default:     add_bytes($urandom_range(1, 10), ($urandom_range(0, 1) == 0) ? 3 : 255, 1'b0);
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    burst_left = $urandom_range(1, 12);

    // Directed planes: single byte at both extremes, a pair, a bare run of
    // three, a literal cut short where a run begins, a literal then a run then
    // a trailing literal, and an alternating plane with no run at all.
    add_run(8'h00, 1);
    send_plane();
    add_run(8'hFF, 1);
    send_plane();
    add_run(8'hFF, 2);
    send_plane();
    add_run(8'h00, 3);
    send_plane();
    add_run(8'h12, 1);
    add_run(8'h34, 1);
    add_run(8'h56, 3);
    send_plane();
    add_run(8'hAA, 2);
    add_run(8'h55, 4);
    add_run(8'h01, 1);
    send_plane();
    add_run(8'h7F, 1);
    add_run(8'h80, 1);
    add_run(8'h7F, 1);
    add_run(8'h80, 1);
    send_plane();

    // Let the encoder drain completely before the random part.
    wait_idle();

    // Longest run, spilling over by up to three bytes.
    add_run($urandom_range(0, 255), 130 + $urandom_range(0, 3));
    send_plane();
    // Longest literal, spilling over, then a short run behind it.
    add_bytes(128 + $urandom_range(0, 3), 255, 1'b1);
    add_run($urandom_range(0, 255), $urandom_range(1, 4));
    send_plane();

    while (rand_sent < RAND_ITEMS) begin
      build_random_plane();
      rand_sent += plane_q.size();
      send_plane();
      if ($urandom_range(0, 5) == 0) wait_idle();
    end

    // Wait for the last words, then give the block time to show anything extra.
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
